@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the following cycle, active during reset as well.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/i2sf_pkg.sv @@
// Shared types and constants for the PCM to I2S halfword formatter.
package i2sf_pkg;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  localparam logic [1:0] REG_MONO  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;

  localparam logic [7:0]  EXP_MAX    = 8'hFF;
  localparam logic [7:0]  EXP_SAT    = 8'd127;
  localparam logic [7:0]  EXP_ZERO   = 8'd96;
  localparam logic [7:0]  EXP_UNITY  = 8'd119;
  localparam logic [7:0]  U8_OFFSET  = 8'h80;
  localparam logic [31:0] Q31_POSMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_NEGMAX = 32'h8000_0000;

  // Decoded sample after the first stage.
  typedef struct packed {
    logic        f32;
    logic        neg;
    logic        sat;
    logic        zero;
    logic        left;
    logic [4:0]  sh;
    logic [23:0] mant;
    logic [31:0] word;
    logic        two;
    logic        mono;
  } s1_t;

  // Sample after the mantissa shift.
  typedef struct packed {
    logic        f32;
    logic        neg;
    logic        sat;
    logic        zero;
    logic [30:0] mag;
    logic [31:0] word;
    logic        two;
    logic        mono;
  } s2_t;

  // Halfword group handed to the serializer.
  typedef struct packed {
    logic [15:0] hi;
    logic [15:0] lo;
    logic        two;
    logic        mono;
  } grp_t;

endpackage

@@ hw/rtl/i2sf_front.sv @@
// First stage: format decode and float field unpacking.
module i2sf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        sample_bits,
  input  logic [1:0]         fmt,
  input  logic               mono,
  output logic               out_valid,
  input  logic               out_ready,
  output i2sf_pkg::s1_t      out_data
);
  import i2sf_pkg::*;

  logic       valid;
  s1_t        data;
  s1_t        data_next;
  logic [7:0] ex;
  logic [7:0] sh_full;
  logic       nan;

  assign ex      = sample_bits[30:23];
  assign nan     = (ex == EXP_MAX) && (sample_bits[22:0] != 23'd0);
  assign sh_full = (ex >= EXP_UNITY) ? (ex - EXP_UNITY) : (EXP_UNITY - ex);

  always_comb begin
    data_next      = '0;
    data_next.f32  = (fmt == FMT_F32);
    data_next.neg  = sample_bits[31];
    data_next.sat  = (ex >= EXP_SAT) && !nan;
    data_next.zero = nan || (ex < EXP_ZERO);
    data_next.left = (ex >= EXP_UNITY);
    data_next.sh   = sh_full[4:0];
    data_next.mant = {1'b1, sample_bits[22:0]};
    data_next.two  = (fmt == FMT_S24) || (fmt == FMT_F32);
    data_next.mono = mono;
    case (fmt)
      FMT_U8:  data_next.word = {sample_bits[7:0] ^ U8_OFFSET, 24'h000000};
      FMT_S16: data_next.word = {sample_bits[15:0], 16'h0000};
      FMT_S24: data_next.word = {sample_bits[23:0], 8'h00};
      default: data_next.word = 32'h0000_0000;
    endcase
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;
endmodule

@@ hw/rtl/i2sf_conv.sv @@
// Second and third stages: mantissa shift, then sign, saturation and grouping.
module i2sf_conv (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2sf_pkg::s1_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output i2sf_pkg::grp_t     out_data
);
  import i2sf_pkg::*;

  logic        valid2;
  s2_t         data2;
  s2_t         data2_next;
  logic        valid3;
  grp_t        data3;
  grp_t        data3_next;
  logic        ready2;
  logic        ready3;
  logic [30:0] mant_ext;
  logic [31:0] mag_ext;
  logic [31:0] q;
  logic [31:0] word;

  assign mant_ext = {7'd0, in_data.mant};

  always_comb begin
    data2_next      = '0;
    data2_next.f32  = in_data.f32;
    data2_next.neg  = in_data.neg;
    data2_next.sat  = in_data.sat;
    data2_next.zero = in_data.zero;
    data2_next.word = in_data.word;
    data2_next.two  = in_data.two;
    data2_next.mono = in_data.mono;
    if (in_data.left) begin
      data2_next.mag = mant_ext << in_data.sh[2:0];
    end else begin
      data2_next.mag = mant_ext >> in_data.sh;
    end
  end

  assign mag_ext = {1'b0, data2.mag};

  always_comb begin
    if (data2.zero) begin
      q = 32'h0000_0000;
    end else if (data2.sat) begin
      q = data2.neg ? Q31_NEGMAX : Q31_POSMAX;
    end else if (data2.neg) begin
      q = 32'h0000_0000 - mag_ext;
    end else begin
      q = mag_ext;
    end
    word            = data2.f32 ? q : data2.word;
    data3_next.hi   = word[31:16];
    data3_next.lo   = word[15:0];
    data3_next.two  = data2.two;
    data3_next.mono = data2.mono;
  end

  assign ready3   = !valid3 || out_ready;
  assign ready2   = !valid2 || ready3;
  assign in_ready = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ready2) begin
        valid2 <= in_valid;
      end
      if (ready3) begin
        valid3 <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && in_valid) begin
      data2 <= data2_next;
    end
    if (ready3 && valid2) begin
      data3 <= data3_next;
    end
  end

  assign out_valid = valid3;
  assign out_data  = data3;
endmodule

@@ hw/rtl/i2sf_ser.sv @@
// Output serializer: sends the halfword group once or twice, one per cycle.
module i2sf_ser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2sf_pkg::grp_t     in_data,
  output logic               strobe,
  output logic [15:0]        halfword,
  output logic               last_of_sample
);
  import i2sf_pkg::*;

  logic       valid;
  grp_t       grp;
  logic [1:0] pos;
  logic [1:0] last_pos;
  logic       at_last;
  logic       load;

  // Last position: one halfword gives 0, two or a mono pair give 1, mono 32-bit gives 3.
  assign last_pos = {grp.two && grp.mono, grp.two || grp.mono};
  assign at_last  = (pos == last_pos);
  assign in_ready = !valid || at_last;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      pos   <= 2'd0;
    end else if (valid) begin
      valid <= !at_last;
      pos   <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= in_data;
    end
  end

  assign strobe         = valid;
  assign halfword       = (grp.two && pos[0]) ? grp.lo : grp.hi;
  assign last_of_sample = valid && at_last;
endmodule

@@ hw/rtl/pcm_sample_to_i2s_formatter.sv @@
// Top level of the PCM sample to I2S transmit halfword formatter.
//
// Use: pulse start with sample_bits while busy is low; the sample is taken at
// that clock edge. Each sample yields one halfword (8/16-bit), two (24-bit or
// float) or twice that for a mono source. Halfwords appear on halfword, one per
// cycle, each marked by strobe for exactly one cycle; last_of_sample flags the
// final halfword of a sample. The receiver must take every strobe.
// Configuration: write mono_source (index 0) and sample_width (index 1) through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only while idle.
// Path: a sample is registered at its accept edge in the decode stage, then
// passes the shift and the sign and saturate stages into the serializer, which
// raises strobe for its first halfword and presents it for one cycle.
// Throughput: the serializer sends one halfword per cycle, so a sample takes
// one, two or four halfwords of output; busy rises when the three stages are
// all full and the serializer is sending a halfword that is not its sample's
// last, and new samples enter every cycle otherwise.
// Reset: rst clears all valid bits and restores mono_source = 0 and
// sample_width = 16-bit; any samples in flight are dropped.
module pcm_sample_to_i2s_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_bits,
  output logic        strobe,
  output logic [15:0] halfword,
  output logic        last_of_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import i2sf_pkg::*;

  logic       mono_source;
  logic [1:0] sample_width;
  logic       front_ready;
  logic       front_valid;
  s1_t        front_data;
  logic       conv_ready;
  logic       conv_valid;
  grp_t       conv_data;
  logic       ser_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_source  <= 1'b0;
      sample_width <= FMT_S16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MONO:  mono_source  <= cfg_data[0];
        REG_WIDTH: sample_width <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign busy = !front_ready;

  i2sf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start),
    .in_ready    (front_ready),
    .sample_bits (sample_bits),
    .fmt         (sample_width),
    .mono        (mono_source),
    .out_valid   (front_valid),
    .out_ready   (conv_ready),
    .out_data    (front_data)
  );

  i2sf_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (conv_ready),
    .in_data   (front_data),
    .out_valid (conv_valid),
    .out_ready (ser_ready),
    .out_data  (conv_data)
  );

  i2sf_ser u_ser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (conv_valid),
    .in_ready       (ser_ready),
    .in_data        (conv_data),
    .strobe         (strobe),
    .halfword       (halfword),
    .last_of_sample (last_of_sample)
  );
endmodule

@@ hw/rtl/i2sf_checker.sv @@
// Port-level checks for the formatter, bound to the top level.
`include "assert_macros.svh"

module i2sf_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic        last_of_sample,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  // A flagged last halfword must be a real transaction.
  `ASSERT_SAME(last_needs_strobe, clk, rst, last_of_sample, strobe)
  // Back-pressure only comes from a sample still being sent out.
  `ASSERT_SAME(busy_while_sending, clk, rst, busy, strobe && !last_of_sample)
  // Reset empties the whole pipeline.
  `ASSERT_NEXT(reset_empties, clk, rst, !strobe && !busy)
  // The configuration port never holds off a write.
  `ASSERT_SAME(cfg_always_ready, clk, rst, cfg_valid, cfg_ready)
endmodule

bind pcm_sample_to_i2s_formatter i2sf_port_checks u_i2sf_port_checks (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .strobe         (strobe),
  .last_of_sample (last_of_sample),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);

@@ tb/sv/i2sf_checker.sv @@
// Checker for the PCM to I2S formatter: predicts halfwords from accepted samples and compares.
module i2sf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] sample_bits,
  input  logic        strobe,
  input  logic [15:0] halfword,
  input  logic        last_of_sample,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          pending_halfwords,
  output int          error_count,
  output int          halfwords_checked
);
  import i2sf_pkg::*;

  typedef struct {
    logic [15:0] word;
    logic        last;
  } tx_word_t;

  tx_word_t   tx_words_due[$];
  logic       mono_mode;
  logic [1:0] sample_fmt;
  int         errs = 0;
  int         seen = 0;

  // Scales an IEEE single by 2^31, truncating toward zero and saturating to int32.
  function automatic logic [31:0] float_to_q31(input logic [31:0] f);
    logic [23:0] mant;
    logic [31:0] mag;
    int          sh;
    mant = {1'b1, f[22:0]};
    if (f[30:23] == EXP_MAX) begin
      if (f[22:0] != 23'd0) return 32'd0;
      return f[31] ? Q31_NEGMAX : Q31_POSMAX;
    end
    if (f[30:23] == 8'd0) return 32'd0;
    sh = int'(f[30:23]) - int'(EXP_UNITY);
    if (sh >= 8) return f[31] ? Q31_NEGMAX : Q31_POSMAX;
    if (sh >= 0) mag = {8'd0, mant} << sh;
    else if (sh > -24) mag = {8'd0, mant} >> (-sh);
    else mag = 32'd0;
    return f[31] ? (32'd0 - mag) : mag;
  endfunction

  task automatic predict_halfwords(input logic [31:0] s);
    logic [15:0] first_hw;
    logic [15:0] second_hw;
    logic [31:0] q;
    int          per_channel;
    int          total;
    tx_word_t    w;
    second_hw = 16'd0;
    case (sample_fmt)
      FMT_U8: begin
        first_hw = {s[7:0] + U8_OFFSET, 8'd0};
        per_channel = 1;
      end
      FMT_S16: begin
        first_hw = s[15:0];
        per_channel = 1;
      end
      FMT_S24: begin
        first_hw = s[23:8];
        second_hw = {s[7:0], 8'd0};
        per_channel = 2;
      end
      default: begin
        q = float_to_q31(s);
        first_hw = q[31:16];
        second_hw = q[15:0];
        per_channel = 2;
      end
    endcase
    total = mono_mode ? 2 * per_channel : per_channel;
    for (int pos = 0; pos < total; pos++) begin
      w.word = (pos % per_channel == 0) ? first_hw : second_hw;
      w.last = (pos == total - 1);
      tx_words_due.push_back(w);
    end
  endtask

  task automatic note_error(input string msg);
    errs++;
    if (errs <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    tx_word_t due;
    if (rst) begin
      tx_words_due.delete();
      mono_mode = 1'b0;
      sample_fmt = FMT_S16;
    end else begin
      // A sample taken at this edge sees the registers as they were before it.
      if (start && !busy) predict_halfwords(sample_bits);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MONO) mono_mode = cfg_data[0];
        else if (cfg_index == REG_WIDTH) sample_fmt = cfg_data[1:0];
      end
      if (strobe) begin
        seen++;
        if (tx_words_due.size() == 0) begin
          note_error($sformatf("unexpected halfword %h last %b", halfword, last_of_sample));
        end else begin
          due = tx_words_due.pop_front();
          if (halfword !== due.word || last_of_sample !== due.last)
            note_error($sformatf("halfword mismatch: expected %h last %b, got %h last %b",
                                 due.word, due.last, halfword, last_of_sample));
        end
      end
    end
    pending_halfwords <= tx_words_due.size();
    error_count <= errs;
    halfwords_checked <= seen;
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the PCM to I2S formatter: drives samples and register writes, gives the verdict.
module tb;
  import i2sf_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SEG_ITEMS     = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] sample_bits = 32'd0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_MONO;
  logic [7:0]  cfg_data = 8'd0;
  logic        busy;
  logic        strobe;
  logic [15:0] halfword;
  logic        last_of_sample;
  logic        cfg_ready;

  int pending_halfwords;
  int error_count;
  int halfwords_checked;
  int cycle_count = 0;
  int samples_sent = 0;
  int settings_done = 0;
  logic [1:0] cur_fmt = FMT_S16;

  always #10 clk = ~clk;

  pcm_sample_to_i2s_formatter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_bits(sample_bits),
    .strobe(strobe), .halfword(halfword), .last_of_sample(last_of_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  i2sf_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_bits(sample_bits),
    .strobe(strobe), .halfword(halfword), .last_of_sample(last_of_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending_halfwords(pending_halfwords), .error_count(error_count),
    .halfwords_checked(halfwords_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The first edge lets the count catch up with a sample accepted at the current edge.
  task automatic wait_all_halfwords();
    do @(posedge clk); while (pending_halfwords != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic mono, input logic [1:0] fmt, input bit spare);
    logic [1:0]  idx [4];
    logic [7:0]  val [4];
    logic [31:0] junk;
    int          n;
    start <= 1'b0;
    wait_all_halfwords();
    junk = $urandom;
    idx[0] = REG_MONO;
    val[0] = {junk[7:1], mono};
    idx[1] = REG_WIDTH;
    val[1] = {junk[15:10], fmt};
    idx[2] = REG_SPARE_A;
    val[2] = junk[23:16];
    idx[3] = REG_SPARE_B;
    val[3] = junk[31:24];
    n = spare ? 4 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_fmt = fmt;
    settings_done++;
  endtask

  task automatic send_sample(input logic [31:0] d, input int idle_pct, input bit pause);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0 || pause) start <= 1'b0;
    if (pause) wait_all_halfwords();
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    sample_bits <= d;
    do @(posedge clk); while (busy);
    samples_sent++;
  endtask

  // Floats get extra weight near the saturation and underflow exponents and on specials.
  function automatic logic [31:0] random_sample(input logic [1:0] fmt);
    logic [31:0] r;
    r = $urandom;
    if (fmt == FMT_F32) begin
      case ($urandom_range(7))
        0: r = {r[31], EXP_MAX, ($urandom_range(1) != 0) ? r[22:0] : 23'd0};
        1: r = {r[31], 8'd0, r[22:0]};
        2, 3, 4, 5: r[30:23] = 8'($urandom_range(EXP_ZERO - 8'd6, EXP_SAT + 8'd8));
        default: ;
      endcase
    end
    return r;
  endfunction

  logic [31:0] u8_cases [5] = '{32'h0000_0000, 32'h0000_007F, 32'h0000_0080,
                                32'hFFFF_FFFF, 32'hABCD_EF12};
  logic [31:0] s24_cases [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0080_0001, 32'hFF12_3456};
  logic [31:0] f32_cases [13] = '{32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000,
                                  32'h3F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0000, 32'h0000_0001, 32'h8000_0000,
                                  32'h3000_0000, 32'h2F80_0000, 32'h4F00_0000,
                                  32'hBEFF_FFFF};
  int idle_phase [4] = '{0, 76, 0, 38};

  initial begin
    int seg;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: stereo 16-bit, with junk in the upper bits.
    send_sample(32'h0000_0000, 0, 1'b0);
    send_sample(32'hFFFF_FFFF, 0, 1'b0);
    send_sample(32'h1234_8000, 0, 1'b0);

    program_regs(1'b1, FMT_U8, 1'b1);
    foreach (u8_cases[i]) send_sample(u8_cases[i], 0, 1'b0);
    program_regs(1'b0, FMT_S24, 1'b0);
    foreach (s24_cases[i]) send_sample(s24_cases[i], 0, 1'b0);
    program_regs(1'b1, FMT_F32, 1'b1);
    foreach (f32_cases[i]) send_sample(f32_cases[i], 0, 1'b0);

    seg = 0;
    foreach (idle_phase[p]) begin
      for (int s = 0; s < 3; s++) begin
        program_regs(((seg / 4) % 2) != 0, 2'(seg % 4), (seg % 3) == 0);
        for (int i = 0; i < SEG_ITEMS; i++)
          send_sample(random_sample(cur_fmt), idle_phase[p], $urandom_range(24) == 0);
        seg++;
      end
    end
    start <= 1'b0;
    wait_all_halfwords();

    $display("Covered %0d samples under %0d register settings: all four formats, mono and stereo.",
             samples_sent, settings_done);
    $display("Compared %0d halfwords, including float saturation, NaN, subnormal and masked bits.",
             halfwords_checked);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
